FILE: design/mm_pkg.sv
// Shared types and constants for the matrix multiply block.
// Holds field widths, register indexes, controller states and the command struct.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mm_pkg;

	// Fixed widths of the element, result and index fields.
	localparam int unsigned ELEM_W = 16;
	localparam int unsigned PROD_W = 32;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned CFG_W  = 4;

	// APB port geometry.
	localparam int unsigned APB_AW = 4;
	localparam int unsigned APB_DW = 32;

	// Dimension registers come out of reset at eight.
	localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

	// Register indexes, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_ROWS_A    = 2'd0,
		REG_INNER_DIM = 2'd1,
		REG_COLS_B    = 2'd2
	} mm_reg_idx_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_MAC   = 2'd1,
		ST_DRAIN = 2'd2
	} mm_state_t;

	// Commands from the controller to the datapath for one cycle.
	typedef struct packed {
		logic             wr_left;
		logic             wr_right;
		logic             rd_valid;
		logic             first;
		logic             last_k;
		logic             last_elem;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} mm_cmd_t;

endpackage

`default_nettype wire

FILE: design/mm_ctrl.sv
// Controller of the matrix multiply block: element counters, load handshake,
// and the address sequencer that walks i, j and k over the two stores.
// Depends on mm_pkg for the state enum and the command struct.
`timescale 1ns / 1ps
`default_nettype none

module mm_ctrl
	import mm_pkg::*;
#(
	parameter int MAX_DIM = 8
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    start,
	input  wire logic                                    target_matrix,
	input  wire logic [CFG_W-1:0]                        rows_a_cfg,
	input  wire logic [CFG_W-1:0]                        inner_cfg,
	input  wire logic [CFG_W-1:0]                        cols_cfg,
	input  wire logic                                    pipe_busy,
	output logic                                         busy,
	output mm_cmd_t                                      cmd,
	output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] wr_addr,
	output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] laddr,
	output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] raddr
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	mm_state_t state_q, state_d;

	logic [CW-1:0] left_count_q, right_count_q;
	logic [CW-1:0] left_next, right_next;
	logic [CW-1:0] left_size, right_size;
	logic [DW-1:0] dim_m, dim_n, dim_p;
	logic          accept, complete;
	logic          wr_left, wr_right;

	logic [IW-1:0] i_q, j_q, k_q;
	logic [AW-1:0] lbase_q, laddr_q, raddr_q;
	logic          i_last, j_last, k_last, issue_last;

	// A register value of zero acts as one, any value above the limit as the limit.
	function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] r);
		if (r == '0)
			return DW'(1);
		else if (int'(r) > MAX_DIM)
			return DW'(MAX_DIM);
		else
			return DW'(r);
	endfunction

	// Effective dimensions and matrix sizes.
	always_comb begin
		dim_m      = clamp_dim(rows_a_cfg);
		dim_n      = clamp_dim(inner_cfg);
		dim_p      = clamp_dim(cols_cfg);
		left_size  = CW'(dim_m) * CW'(dim_n);
		right_size = CW'(dim_n) * CW'(dim_p);
	end

	// Load transaction: store the element if its matrix still has room, then
	// judge completeness with the updated counts.
	always_comb begin
		accept     = start && (state_q == ST_IDLE);
		wr_left    = accept && !target_matrix && (left_count_q < left_size);
		wr_right   = accept && target_matrix && (right_count_q < right_size);
		left_next  = left_count_q + (wr_left ? CW'(1) : CW'(0));
		right_next = right_count_q + (wr_right ? CW'(1) : CW'(0));
		complete   = (left_next >= left_size) && (right_next >= right_size);
		wr_addr    = target_matrix ? AW'(right_count_q) : AW'(left_count_q);
	end

	// Element counters; both return to zero when a product starts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_count_q  <= '0;
			right_count_q <= '0;
		end else if (accept) begin
			left_count_q  <= complete ? '0 : left_next;
			right_count_q <= complete ? '0 : right_next;
		end
	end

	// Loop end conditions for the inner, column and row counters.
	always_comb begin
		k_last     = (DW'(k_q) == (dim_n - DW'(1)));
		j_last     = (DW'(j_q) == (dim_p - DW'(1)));
		i_last     = (DW'(i_q) == (dim_m - DW'(1)));
		issue_last = k_last && j_last && i_last;
	end

	// Address sequencer: left address is row base plus k, right address is
	// j plus k times the column count, both built by adding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			lbase_q <= '0;
			laddr_q <= '0;
			raddr_q <= '0;
		end else if (accept && complete) begin
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			lbase_q <= '0;
			laddr_q <= '0;
			raddr_q <= '0;
		end else if (state_q == ST_MAC) begin
			if (!k_last) begin
				k_q     <= k_q + IW'(1);
				laddr_q <= laddr_q + AW'(1);
				raddr_q <= raddr_q + AW'(dim_p);
			end else begin
				k_q <= '0;
				if (!j_last) begin
					j_q     <= j_q + IW'(1);
					laddr_q <= lbase_q;
					raddr_q <= AW'(j_q) + AW'(1);
				end else begin
					j_q     <= '0;
					i_q     <= i_q + IW'(1);
					lbase_q <= lbase_q + AW'(dim_n);
					laddr_q <= lbase_q + AW'(dim_n);
					raddr_q <= '0;
				end
			end
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && complete)
					state_d = ST_MAC;
			end
			ST_MAC: begin
				if (issue_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!pipe_busy)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs to the datapath and the load port.
	always_comb begin
		busy          = (state_q != ST_IDLE);
		cmd.wr_left   = wr_left;
		cmd.wr_right  = wr_right;
		cmd.rd_valid  = (state_q == ST_MAC);
		cmd.first     = (k_q == '0);
		cmd.last_k    = k_last;
		cmd.last_elem = i_last && j_last;
		cmd.row       = IDX_W'(i_q);
		cmd.col       = IDX_W'(j_q);
		laddr         = laddr_q;
		raddr         = raddr_q;
	end

	// A completing load always starts the multiply on the next cycle.
	a_start_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && complete) |=> (state_q == ST_MAC))
		else $error("completed load did not start the multiply");

	// Reads only walk inside the current dimensions.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_valid |-> ((DW'(k_q) < dim_n) && (DW'(j_q) < dim_p) && (DW'(i_q) < dim_m)))
		else $error("loop index outside the matrix dimensions");

	// The stores are never written while products are still in flight.
	a_no_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_left || cmd.wr_right) |-> !pipe_busy)
		else $error("store written while the datapath was busy");

	// After the last issue the pipeline is seen busy before returning idle.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC && issue_last) |=> pipe_busy)
		else $error("last product issue did not enter the pipeline");

endmodule

`default_nettype wire

FILE: design/mm_dp.sv
// Datapath of the matrix multiply block: the two element stores, the
// multiply-accumulate pipeline, saturation and the registered result.
// Depends on mm_pkg for field widths and the command struct.
`timescale 1ns / 1ps
`default_nettype none

module mm_dp
	import mm_pkg::*;
#(
	parameter int MAX_DIM = 8
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire mm_cmd_t                                 cmd,
	input  wire logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] wr_addr,
	input  wire logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] laddr,
	input  wire logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] raddr,
	input  wire logic signed [ELEM_W-1:0]                element_value,
	output logic                                         pipe_busy,
	output logic                                         out_valid,
	output logic signed [PROD_W-1:0]                     product_value,
	output logic [IDX_W-1:0]                             out_row,
	output logic [IDX_W-1:0]                             out_col,
	output logic                                         last_element
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int ACC_W = PROD_W + $clog2(MAX_DIM) + 1;

	logic signed [ELEM_W-1:0] left_mem  [DEPTH];
	logic signed [ELEM_W-1:0] right_mem [DEPTH];

	logic signed [ELEM_W-1:0] a_s1, b_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [PROD_W-1:0] sat_val;
	logic [ACC_W-PROD_W:0]    acc_hi;

	logic             v_s1, v_s2, done_s3;
	logic             first_s1, first_s2;
	logic             lastk_s1, lastk_s2;
	logic             lastel_s1, lastel_s2, lastel_s3;
	logic [IDX_W-1:0] row_s1, row_s2, row_s3;
	logic [IDX_W-1:0] col_s1, col_s2, col_s3;
	logic             out_valid_q;

	// Element stores: one write port for loading, one registered read port each.
	always_ff @(posedge clk) begin
		if (cmd.wr_left)
			left_mem[wr_addr] <= element_value;
		a_s1 <= left_mem[laddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_right)
			right_mem[wr_addr] <= element_value;
		b_s1 <= right_mem[raddr];
	end

	// Valid and end-of-sum flags along the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			done_s3     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1        <= cmd.rd_valid;
			v_s2        <= v_s1;
			done_s3     <= v_s2 && lastk_s2;
			out_valid_q <= done_s3;
		end
	end

	// Tags that travel with each read.
	always_ff @(posedge clk) begin
		first_s1  <= cmd.first;
		lastk_s1  <= cmd.last_k;
		lastel_s1 <= cmd.last_elem;
		row_s1    <= cmd.row;
		col_s1    <= cmd.col;
		first_s2  <= first_s1;
		lastk_s2  <= lastk_s1;
		lastel_s2 <= lastel_s1;
		row_s2    <= row_s1;
		col_s2    <= col_s1;
		if (v_s2 && lastk_s2) begin
			lastel_s3 <= lastel_s2;
			row_s3    <= row_s2;
			col_s3    <= col_s2;
		end
	end

	// Multiply stage, then accumulate; the first product of a sum reloads.
	assign prod_ext = {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(a_s1) * PROD_W'(b_s1);
		if (v_s2)
			acc_q <= first_s2 ? prod_ext : (acc_q + prod_ext);
	end

	// Saturate the finished sum to 32 signed bits.
	always_comb begin
		acc_hi = acc_q[ACC_W-1:PROD_W-1];
		if ((&acc_hi) || !(|acc_hi))
			sat_val = acc_q[PROD_W-1:0];
		else if (acc_q[ACC_W-1])
			sat_val = {1'b1, {(PROD_W - 1){1'b0}}};
		else
			sat_val = {1'b0, {(PROD_W - 1){1'b1}}};
	end

	// Result register, shown for one cycle.
	always_ff @(posedge clk) begin
		if (done_s3) begin
			product_value <= sat_val;
			out_row       <= row_s3;
			out_col       <= col_s3;
			last_element  <= lastel_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign pipe_busy = v_s1 || v_s2 || done_s3;

endmodule

`default_nettype wire

FILE: design/matrix_multiply.sv
// Top level of the matrix multiply block: APB register file for the three
// dimensions, plus the controller and datapath instances.
// Depends on mm_pkg, mm_ctrl and mm_dp.
//
//  Port group   Direction  Transaction
//  apb          in/out     psel&penable&pwrite&pready writes rows_a/inner_dim/cols_b
//  load         in         start&!busy takes target_matrix and element_value
//  result       out        out_valid strobes product_value, out_row, out_col, last_element
//
// Busy stays low until the load that completes both matrices. Then busy rises while
// the single multiply-accumulate unit takes one store read per cycle, and stays high
// while the read, multiply, accumulate and result registers drain.
// Results appear one per strobe; the receiver cannot stall.
// Reset is asynchronous, active low; the stores hold nothing meaningful until loaded.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply
	import mm_pkg::*;
#(
	parameter int MAX_DIM = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_AW-1:0]        paddr,
	input  wire logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]             prdata,
	output logic                          pready,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     target_matrix,
	input  wire logic signed [ELEM_W-1:0] element_value,
	output logic                          out_valid,
	output logic signed [PROD_W-1:0]      product_value,
	output logic [IDX_W-1:0]              out_row,
	output logic [IDX_W-1:0]              out_col,
	output logic                          last_element
);

	localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

	logic [CFG_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
	logic             wr_en;
	mm_reg_idx_t      reg_idx;
	mm_cmd_t          cmd;
	logic             pipe_busy;
	logic [AW-1:0]    wr_addr, laddr, raddr;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = mm_reg_idx_t'(paddr[3:2]);

	// Dimension registers, written in the APB access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_RESET;
			inner_dim_q <= DIM_RESET;
			cols_b_q    <= DIM_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ROWS_A:    rows_a_q    <= pwdata[CFG_W-1:0];
				REG_INNER_DIM: inner_dim_q <= pwdata[CFG_W-1:0];
				REG_COLS_B:    cols_b_q    <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back decoder.
	always_comb begin
		unique case (reg_idx)
			REG_ROWS_A:    prdata = APB_DW'(rows_a_q);
			REG_INNER_DIM: prdata = APB_DW'(inner_dim_q);
			REG_COLS_B:    prdata = APB_DW'(cols_b_q);
			default:       prdata = '0;
		endcase
	end

	mm_ctrl #(
		.MAX_DIM(MAX_DIM)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.target_matrix(target_matrix),
		.rows_a_cfg   (rows_a_q),
		.inner_cfg    (inner_dim_q),
		.cols_cfg     (cols_b_q),
		.pipe_busy    (pipe_busy),
		.busy         (busy),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.laddr        (laddr),
		.raddr        (raddr)
	);

	mm_dp #(
		.MAX_DIM(MAX_DIM)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.laddr        (laddr),
		.raddr        (raddr),
		.element_value(element_value),
		.pipe_busy    (pipe_busy),
		.out_valid    (out_valid),
		.product_value(product_value),
		.out_row      (out_row),
		.out_col      (out_col),
		.last_element (last_element)
	);

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for matrix_multiply: element loads go in through a queue-fed driver,
// product elements are checked by a monitor against an in-bench integer matrix product.
// Depends on mm_pkg and the matrix_multiply design files.
`timescale 1ns / 1ps

module testbench;
	import mm_pkg::*;

	localparam int          MAX_DIM       = 8;
	localparam int unsigned LOAD_BUDGET   = 170;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned PRINT_CAP     = 40;
	localparam longint      PROD_MAX      = 64'sd2147483647;
	localparam longint      PROD_MIN      = -64'sd2147483648;

	// One element load transaction; hold makes the driver wait until all products are out.
	typedef struct {
		bit                        to_right;
		logic signed [ELEM_W-1:0]  value;
		bit                        hold;
	} element_t;

	// One element of the product matrix.
	typedef struct {
		logic signed [PROD_W-1:0] value;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic                     last;
	} product_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_AW-1:0]        paddr = '0;
	logic [APB_DW-1:0]        pwdata = '0;
	logic [APB_DW-1:0]        prdata;
	logic                     pready;
	logic                     start = 1'b0;
	logic                     busy;
	logic                     target_matrix = 1'b0;
	logic signed [ELEM_W-1:0] element_value = '0;
	logic                     out_valid;
	logic signed [PROD_W-1:0] product_value;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;
	logic                     last_element;

	// Loads waiting to be driven and product elements waiting to be seen.
	element_t element_queue[$];
	product_t pending_products[$];
	product_t want_product;

	// Mirror of the dimension registers and of the two element stores.
	logic [CFG_W-1:0]         rows_cfg  = DIM_RESET;
	logic [CFG_W-1:0]         inner_cfg = DIM_RESET;
	logic [CFG_W-1:0]         cols_cfg  = DIM_RESET;
	logic signed [ELEM_W-1:0] left_mem [MAX_DIM*MAX_DIM];
	logic signed [ELEM_W-1:0] right_mem [MAX_DIM*MAX_DIM];
	int unsigned              left_fill = 0;
	int unsigned              right_fill = 0;

	int unsigned gap_pct = 0;
	int unsigned random_loads = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	matrix_multiply #(
		.MAX_DIM(MAX_DIM)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.target_matrix(target_matrix),
		.element_value(element_value),
		.out_valid(out_valid),
		.product_value(product_value),
		.out_row(out_row),
		.out_col(out_col),
		.last_element(last_element)
	);

	always #4 clk = ~clk;

	task automatic flag_mismatch(input string msg);
		if (error_count < PRINT_CAP) begin
			$display("MISMATCH at %0t: %s", $time, msg);
		end
		error_count++;
	endtask

	// A dimension register of zero acts as one, anything above MAX_DIM acts as MAX_DIM.
	function automatic int unsigned eff_dim(input logic [CFG_W-1:0] r);
		if (r == 0) return 1;
		if (r > MAX_DIM) return MAX_DIM;
		return r;
	endfunction

	// Store one accepted element and, once both matrices are complete, queue the product.
	task automatic take_element(input element_t ld);
		int unsigned m;
		int unsigned n;
		int unsigned p;
		longint      acc;
		product_t    res;
		m = eff_dim(rows_cfg);
		n = eff_dim(inner_cfg);
		p = eff_dim(cols_cfg);
		if (!ld.to_right) begin
			if (left_fill < m * n) begin
				left_mem[left_fill] = ld.value;
				left_fill++;
			end
		end else begin
			if (right_fill < n * p) begin
				right_mem[right_fill] = ld.value;
				right_fill++;
			end
		end
		if (left_fill >= m * n && right_fill >= n * p) begin
			for (int i = 0; i < m; i++) begin
				for (int j = 0; j < p; j++) begin
					acc = 0;
					for (int k = 0; k < n; k++) begin
						acc += longint'(left_mem[i*n+k]) * longint'(right_mem[k*p+j]);
					end
					if (acc > PROD_MAX) acc = PROD_MAX;
					if (acc < PROD_MIN) acc = PROD_MIN;
					res.value = acc[PROD_W-1:0];
					res.row   = IDX_W'(i);
					res.col   = IDX_W'(j);
					res.last  = (i == m - 1) && (j == p - 1);
					pending_products.push_back(res);
				end
			end
			left_fill  = 0;
			right_fill = 0;
		end
	endtask

	// Driver: offers the front of the queue; an offered element stays put until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start         <= 1'b0;
			target_matrix <= 1'b0;
			element_value <= '0;
		end else begin
			if (start && !busy) begin
				take_element(element_queue.pop_front());
			end
			if (!(start && busy)) begin
				if (element_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct &&
				    !(element_queue[0].hold && pending_products.size() != 0)) begin
					start         <= 1'b1;
					target_matrix <= element_queue[0].to_right;
					element_value <= element_queue[0].value;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every result transaction is matched against the oldest expected element.
	always @(posedge clk) begin
		if (arst_n && out_valid) begin
			if (pending_products.size() == 0) begin
				flag_mismatch($sformatf("unexpected result row %0d col %0d", out_row, out_col));
			end else begin
				want_product = pending_products.pop_front();
				if (product_value !== want_product.value)
					flag_mismatch($sformatf("product_value %0d, expected %0d",
						product_value, want_product.value));
				if (out_row !== want_product.row)
					flag_mismatch($sformatf("out_row %0d, expected %0d",
						out_row, want_product.row));
				if (out_col !== want_product.col)
					flag_mismatch($sformatf("out_col %0d, expected %0d",
						out_col, want_product.col));
				if (last_element !== want_product.last)
					flag_mismatch($sformatf("last_element %0b, expected %0b",
						last_element, want_product.last));
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// One APB write transaction: setup cycle, then access until pready.
	task automatic write_dim(input mm_reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_ROWS_A:    rows_cfg  = val;
			REG_INNER_DIM: inner_cfg = val;
			REG_COLS_B:    cols_cfg  = val;
			default: ;
		endcase
	endtask

	task automatic set_dims(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
	                        input logic [CFG_W-1:0] c);
		write_dim(REG_ROWS_A, r);
		write_dim(REG_INNER_DIM, k);
		write_dim(REG_COLS_B, c);
	endtask

	task automatic queue_element(input bit to_right, input logic signed [ELEM_W-1:0] v,
	                             input bit hold);
		element_t ld;
		ld.to_right = to_right;
		ld.value    = v;
		ld.hold     = hold;
		element_queue.push_back(ld);
	endtask

	// Random element value, biased toward the extremes so that sums saturate.
	function automatic logic signed [ELEM_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h8001;
			3: return '0;
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	// Queue complete products with random interleaving of the two matrices, a few surplus
	// elements that the block ignores, and optionally a partial load left for the next phase.
	task automatic queue_products(input int unsigned min_loads, input bit tail);
		int unsigned m;
		int unsigned n;
		int unsigned p;
		int unsigned a_left;
		int unsigned b_left;
		int unsigned issued;
		bit          hold;
		m = eff_dim(rows_cfg);
		n = eff_dim(inner_cfg);
		p = eff_dim(cols_cfg);
		issued = 0;
		a_left = (left_fill < m * n) ? m * n - left_fill : 0;
		b_left = (right_fill < n * p) ? n * p - right_fill : 0;
		do begin
			hold = ($urandom_range(0, 3) == 0);
			do begin
				if ((a_left == 0) != (b_left == 0) && $urandom_range(0, 99) < 8) begin
					// Surplus element for the matrix that is already full.
					queue_element(a_left == 0, pick_value(), hold);
					hold = 1'b0;
				end
				if (a_left != 0 && (b_left == 0 || $urandom_range(0, 1) == 0)) begin
					queue_element(1'b0, pick_value(), hold);
					a_left--;
				end else if (b_left != 0) begin
					queue_element(1'b1, pick_value(), hold);
					b_left--;
				end else begin
					// Both already complete after a shrink: any element triggers the product.
					queue_element($urandom_range(0, 1), pick_value(), hold);
				end
				hold = 1'b0;
				issued++;
			end while (a_left != 0 || b_left != 0);
			a_left = m * n;
			b_left = n * p;
		end while (issued < min_loads);
		if (tail) begin
			a_left = $urandom_range(0, m * n - 1);
			b_left = $urandom_range(0, n * p - 1);
			issued += a_left + b_left;
			repeat (a_left) queue_element(1'b0, pick_value(), 1'b0);
			repeat (b_left) queue_element(1'b1, pick_value(), 1'b0);
		end
		random_loads += issued;
	endtask

	// Wait until every load is taken and every product element has come out.
	task automatic wait_quiet();
		while (element_queue.size() != 0 || start) @(posedge clk);
		while (pending_products.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned ph;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Register value zero acts as one: single-element products at the value extremes,
		// a surplus element that is ignored, and a load held until the results are out.
		gap_pct = 0;
		set_dims(4'd0, 4'd0, 4'd0);
		queue_element(1'b0, 16'h7FFF, 1'b0);
		queue_element(1'b1, 16'h7FFF, 1'b0);
		queue_element(1'b1, 16'h8000, 1'b1);
		queue_element(1'b1, 16'h0001, 1'b0);
		queue_element(1'b0, 16'h8000, 1'b0);
		queue_element(1'b1, 16'h8000, 1'b0);
		queue_element(1'b0, 16'h7FFF, 1'b0);
		wait_quiet();

		// A three-term sum that saturates to the most negative value.
		set_dims(4'd1, 4'd3, 4'd1);
		repeat (3) queue_element(1'b0, 16'h8000, 1'b0);
		repeat (3) queue_element(1'b1, 16'h7FFF, 1'b0);
		wait_quiet();

		// Dimensions shrink mid-load: the left matrix is then already over-full.
		set_dims(4'd2, 4'd2, 4'd2);
		queue_element(1'b0, 16'h1000, 1'b0);
		queue_element(1'b0, 16'hF000, 1'b0);
		queue_element(1'b0, 16'h0800, 1'b0);
		queue_element(1'b1, 16'h2000, 1'b0);
		wait_quiet();
		write_dim(REG_ROWS_A, 4'd1);
		write_dim(REG_COLS_B, 4'd1);
		queue_element(1'b1, 16'h7FFF, 1'b0);
		wait_quiet();

		// Random phases: fixed shapes for the extremes first, then small random shapes.
		ph = 0;
		while (random_loads < LOAD_BUDGET) begin
			case (ph)
				0: set_dims(4'd2, 4'd3, 4'd2);
				1: set_dims(4'd3, 4'd2, 4'd4);
				2: set_dims(4'd8, 4'd2, 4'd8);
				3: set_dims(4'd2, 4'd15, 4'd1);
				4: set_dims(4'd9, 4'd1, 4'd12);
				default: set_dims(CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 4)),
				                  CFG_W'($urandom_range(0, 4)));
			endcase
			case (ph % 3)
				0: gap_pct = 0;
				1: gap_pct = 58;
				default: gap_pct = 13;
			endcase
			queue_products(16, $urandom_range(0, 1));
			wait_quiet();
			ph++;
		end

		if (error_count == 0 && pending_products.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

FILE: matrix_multiply.f
design/mm_pkg.sv
design/mm_ctrl.sv
design/mm_dp.sv
design/matrix_multiply.sv
tb/sv/testbench.sv
